// File: rtl/core/moe_topk_expert_select_assert.svh
// ----------------------------------------------------------------------------
// moe_topk_expert_select_assert
// assertion macros for the expert select block
// ----------------------------------------------------------------------------
`ifndef MOE_TOPK_EXPERT_SELECT_ASSERT_SVH
`define MOE_TOPK_EXPERT_SELECT_ASSERT_SVH

// property that must hold on every clock edge outside reset
`define MTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// consequent must hold in the same cycle as the antecedent
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// consequent must hold in the cycle after the antecedent
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared constants, types and float compare helpers for top-k expert select
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned MaxExperts = 64;
  localparam int unsigned MaxPicks   = 8;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned CntW       = 7;
  localparam int unsigned KW         = 4;
  localparam int unsigned PickW      = $clog2(MaxPicks);
  localparam int unsigned PCntW      = $clog2(MaxPicks + 1);
  localparam int unsigned AddrW      = 3;

  localparam logic [31:0] NegFloor   = 32'hF149F2CA;
  localparam logic [KW-1:0]   KReset   = KW'(6);
  localparam logic [CntW-1:0] CntReset = CntW'(64);

  localparam logic [AddrW-1:0] RegKUsed       = AddrW'(0);
  localparam logic [AddrW-1:0] RegExpertCount = AddrW'(4);

  typedef struct packed {
    logic [IdxW-1:0] expert_index;
    logic [31:0]     weight_bits;
    logic            last_pick;
  } result_t;

  typedef struct packed {
    logic [KW-1:0]   k_used;
    logic [CntW-1:0] token_len;
  } cfg_t;

  function automatic logic fnan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // a >= b for non-nan floats, with +0 equal to -0
  function automatic logic fge(input logic [31:0] a, input logic [31:0] b);
    logic az, bz;
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    if (az && bz) return 1'b1;
    if (a[31] != b[31]) return b[31];
    if (!a[31]) return a[30:0] >= b[30:0];
    return a[30:0] <= b[30:0];
  endfunction

  // any nan compares false
  function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
    return !fnan(a) && !fnan(b) && !fge(b, a);
  endfunction

endpackage

// File: rtl/core/mts_stream_if.sv
// ----------------------------------------------------------------------------
// mts_stream_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface mts_stream_if #(parameter type payload_t = logic [31:0]);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/moe_topk_expert_select.sv
// ----------------------------------------------------------------------------
// moe_topk_expert_select
// top-k router expert selection over a stream of float scores
// ----------------------------------------------------------------------------
// scores enter on score_in, one item per expert in order; each item is
// compared against all eight held entries at once and inserted in place.
// a new score is taken every cycle unless the input stalls as below.
// after token length scores the sorted list is copied to a snapshot and the
// live list clears the same cycle, so the next token may start at once.
// the snapshot goes to an output stage that sends k_used result items
// (clamped to 1..8), one per cycle, descending, last_pick on the final one;
// an idle stage takes the registered snapshot and then registers valid.
// when the receiver stalls, the output stage holds; the input stalls only if
// a token ends while a previous snapshot is still waiting.
// reset gives k_used 6, token length 64 and an empty list; configuration is
// written over the apb port (k_used at 0x0, token length at 0x4).
// ----------------------------------------------------------------------------
module moe_topk_expert_select (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  mts_stream_if.sink                score_in,
  mts_stream_if.source              result_out,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mts_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mts_pkg::*;

  cfg_t             cfg;
  logic             snap_valid, snap_take;
  logic [IdxW-1:0]  snap_idx   [MaxPicks];
  logic [31:0]      snap_score [MaxPicks];
  logic [PCntW-1:0] snap_k;

  mts_cfg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  mts_topk_list u_list (
    .clk_i, .rst_ni,
    .in_valid_i(score_in.valid), .in_ready_o(score_in.ready), .score_i(score_in.data),
    .cfg_i(cfg), .snap_valid_o(snap_valid), .snap_take_i(snap_take),
    .snap_idx_o(snap_idx), .snap_score_o(snap_score), .snap_k_o(snap_k)
  );

  mts_emitter u_emit (
    .clk_i, .rst_ni, .snap_valid_i(snap_valid), .snap_take_o(snap_take),
    .snap_idx_i(snap_idx), .snap_score_i(snap_score), .snap_k_i(snap_k),
    .res(result_out)
  );
endmodule

// File: rtl/core/mts_cfg_regs.sv
// ----------------------------------------------------------------------------
// mts_cfg_regs
// apb register file holding k_used and the token length
// ----------------------------------------------------------------------------
module mts_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mts_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mts_pkg::cfg_t              cfg_o
);
  import mts_pkg::*;

  logic [KW-1:0]   k_q;
  logic [CntW-1:0] cnt_q;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= KReset;
      cnt_q <= CntReset;
    end else if (wr) begin
      unique case (paddr)
        RegKUsed:       k_q   <= pwdata[KW-1:0];
        RegExpertCount: cnt_q <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      RegKUsed:       prdata = {{(32-KW){1'b0}}, k_q};
      RegExpertCount: prdata = {{(32-CntW){1'b0}}, cnt_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o.k_used    = k_q;
  assign cfg_o.token_len = cnt_q;
endmodule

// File: rtl/core/mts_topk_list.sv
// ----------------------------------------------------------------------------
// mts_topk_list
// sorted insertion list; one score per cycle unless a waiting snapshot stalls it, snapshot handed off at token end
// ----------------------------------------------------------------------------
module mts_topk_list (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [31:0]               score_i,
  input  mts_pkg::cfg_t             cfg_i,
  output logic                      snap_valid_o,
  input  logic                      snap_take_i,
  output logic [mts_pkg::IdxW-1:0]  snap_idx_o   [mts_pkg::MaxPicks],
  output logic [31:0]               snap_score_o [mts_pkg::MaxPicks],
  output logic [mts_pkg::PCntW-1:0] snap_k_o
);
  import mts_pkg::*;

  logic [IdxW-1:0]  idx_q   [MaxPicks];
  logic [31:0]      score_q [MaxPicks];
  logic [IdxW-1:0]  idx_d   [MaxPicks];
  logic [31:0]      score_d [MaxPicks];
  logic [CntW-1:0]  seen_q;
  logic [CntW-1:0]  count;
  logic [PCntW-1:0] k_eff;
  logic             snap_q;
  logic [IdxW-1:0]  sidx_q   [MaxPicks];
  logic [31:0]      sscore_q [MaxPicks];
  logic [PCntW-1:0] sk_q;
  logic [MaxPicks-1:0] keep;
  logic             take, ins, done;

  always_comb begin
    count = cfg_i.token_len;
    if (count == '0) count = CntW'(1);
    if (count > CntW'(MaxExperts)) count = CntW'(MaxExperts);
    k_eff = PCntW'(cfg_i.k_used);
    if (cfg_i.k_used == '0) k_eff = PCntW'(1);
    if (cfg_i.k_used > KW'(MaxPicks)) k_eff = PCntW'(MaxPicks);
  end

  // a held snapshot blocks only when the token ends now and it is still not taken
  assign in_ready_o = !snap_q || snap_take_i || !done;
  assign take = in_valid_i && in_ready_o;
  assign ins  = fgt(score_i, NegFloor);
  assign done = (seen_q + CntW'(1)) >= count;

  always_comb begin
    for (int j = 0; j < MaxPicks; j++) begin
      keep[j] = fge(score_q[j], score_i) || !ins;
    end
    for (int j = 0; j < MaxPicks; j++) begin
      if (keep[j]) begin
        idx_d[j] = idx_q[j];
        score_d[j] = score_q[j];
      end else if (j == 0 || keep[(j == 0) ? 0 : j-1]) begin
        idx_d[j] = seen_q[IdxW-1:0];
        score_d[j] = score_i;
      end else begin
        idx_d[j] = idx_q[(j == 0) ? 0 : j-1];
        score_d[j] = score_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      snap_q <= 1'b0;
      for (int j = 0; j < MaxPicks; j++) begin
        idx_q[j] <= '0;
        score_q[j] <= NegFloor;
      end
    end else begin
      if (take && done) begin
        snap_q <= 1'b1;
      end else if (snap_take_i) begin
        snap_q <= 1'b0;
      end
      if (take) begin
        if (done) begin
          seen_q <= '0;
          for (int j = 0; j < MaxPicks; j++) begin
            idx_q[j] <= '0;
            score_q[j] <= NegFloor;
          end
        end else begin
          seen_q <= seen_q + CntW'(1);
          idx_q <= idx_d;
          score_q <= score_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && done) begin
      sidx_q <= idx_d;
      sscore_q <= score_d;
      sk_q <= k_eff;
    end
  end

  assign snap_valid_o = snap_q;
  assign snap_idx_o   = sidx_q;
  assign snap_score_o = sscore_q;
  assign snap_k_o     = sk_q;
endmodule

// File: rtl/core/mts_emitter.sv
// ----------------------------------------------------------------------------
// mts_emitter
// streams a snapshot of the list out as k_used result items (clamped to 1..8)
// ----------------------------------------------------------------------------
module mts_emitter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      snap_valid_i,
  output logic                      snap_take_o,
  input  logic [mts_pkg::IdxW-1:0]  snap_idx_i   [mts_pkg::MaxPicks],
  input  logic [31:0]               snap_score_i [mts_pkg::MaxPicks],
  input  logic [mts_pkg::PCntW-1:0] snap_k_i,
  mts_stream_if.source              res
);
  import mts_pkg::*;

  logic [IdxW-1:0]  idx_q   [MaxPicks];
  logic [31:0]      score_q [MaxPicks];
  logic [PCntW-1:0] k_q;
  logic [PickW-1:0] pos_q;
  logic             busy_q, last;

  assign last = (PCntW'(pos_q) + PCntW'(1)) == k_q;
  assign snap_take_o = snap_valid_i && (!busy_q || (res.ready && last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (snap_take_o) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
    end else if (busy_q && res.ready) begin
      if (last) busy_q <= 1'b0;
      pos_q <= pos_q + PickW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take_o) begin
      idx_q   <= snap_idx_i;
      score_q <= snap_score_i;
      k_q     <= snap_k_i;
    end
  end

  assign res.valid             = busy_q;
  assign res.data.expert_index = idx_q[pos_q];
  assign res.data.weight_bits  = score_q[pos_q];
  assign res.data.last_pick    = last;
endmodule

// File: rtl/core/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// port-level checks for the expert select block
// ----------------------------------------------------------------------------
`include "moe_topk_expert_select_assert.svh"

module mts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_weight_i,
  input logic        out_last_i,
  input logic        pready_i
);
  import mts_pkg::*;

  localparam logic [30:0] FloorMag = NegFloor[30:0];

  `MTS_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `MTS_ASSERT_IMP(a_weight_floor, clk_i, rst_ni, out_valid_i, !out_weight_i[31] || (out_weight_i[30:0] <= FloorMag))
  `MTS_ASSERT(a_pready, clk_i, rst_ni, pready_i)
  `MTS_ASSERT_NXT(a_last_gap, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, out_valid_i)
endmodule

bind moe_topk_expert_select mts_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid_i(result_out.valid), .out_ready_i(result_out.ready),
  .out_weight_i(result_out.data.weight_bits), .out_last_i(result_out.data.last_pick),
  .pready_i(pready)
);
